// ===== src/kdlp_pkg.sv =====
`timescale 1ns / 1ps

package kdlp_pkg;

    // fixed field widths
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    // button roles
    localparam int END_BUTTON = 3;
    localparam int MAX_BUTTONS = 16;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CONFIRM    = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd200;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [CFG_W-1:0] CONFIRM_RST    = 16'd600;

    // what the end button lane found for one beat
    typedef struct packed {
        logic fire;
        logic is_reset;
        logic confirm;
    } t_end_res;

endpackage

// ===== src/kdlp_lane.sv =====
`timescale 1ns / 1ps

module kdlp_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_down,
    input  logic [kdlp_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [kdlp_pkg::CFG_W-1:0]   i_debounce_ms,
    output logic                         o_hit
);
    import kdlp_pkg::*;

    logic [TIME_W-1:0] r_last_ms;
    logic [TIME_W-1:0] w_gap;

    // wrapping difference since last accepted press
    assign w_gap = i_now_ms - r_last_ms;
    assign o_hit = i_down && (w_gap > {{(TIME_W-CFG_W){1'b0}}, i_debounce_ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ms <= '0;
        end else if (i_accept && o_hit) begin
            r_last_ms <= i_now_ms;
        end
    end

endmodule

// ===== src/kdlp_end_lane.sv =====
`timescale 1ns / 1ps

module kdlp_end_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_down,
    input  logic [kdlp_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [kdlp_pkg::CFG_W-1:0]   i_long_press_ms,
    input  logic [kdlp_pkg::CFG_W-1:0]   i_confirm_ms,
    output kdlp_pkg::t_end_res           o_res
);
    import kdlp_pkg::*;

    logic [TIME_W-1:0] r_start_ms;
    logic              r_end_held;
    logic              r_reset_sent;
    logic [TIME_W-1:0] n_start_ms;
    logic              n_end_held;
    logic              n_reset_sent;
    logic [TIME_W-1:0] w_hold;
    logic              w_long;

    // a fresh hold starts at this beat's timestamp
    assign n_start_ms = r_end_held ? r_start_ms : i_now_ms;
    assign w_hold     = i_now_ms - n_start_ms;
    assign w_long     = w_hold >= {{(TIME_W-CFG_W){1'b0}}, i_long_press_ms};

    always_comb begin
        o_res = '0;
        if (i_down) begin
            o_res.fire     = !r_reset_sent && w_long;
            o_res.is_reset = 1'b1;
            n_end_held     = 1'b1;
            n_reset_sent   = r_reset_sent || w_long;
            o_res.confirm  = !n_reset_sent &&
                             (w_hold > {{(TIME_W-CFG_W){1'b0}}, i_confirm_ms});
        end else begin
            // release before reset fired gives end
            o_res.fire     = r_end_held && !r_reset_sent;
            n_end_held     = 1'b0;
            n_reset_sent   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_ms   <= '0;
            r_end_held   <= 1'b0;
            r_reset_sent <= 1'b0;
        end else if (i_accept) begin
            r_start_ms   <= n_start_ms;
            r_end_held   <= n_end_held;
            r_reset_sent <= n_reset_sent;
        end
    end

`ifndef SYNTHESIS
    a_sent_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reset_sent |-> r_end_held)
        else $error("reset marked sent without a hold");
    a_no_confirm_on_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.confirm |-> !(o_res.fire && o_res.is_reset))
        else $error("confirm shown in the beat that fires reset");
`endif

endmodule

// ===== src/kdlp_merge.sv =====
`timescale 1ns / 1ps

module kdlp_merge #(
    parameter int MASK_W = 7,
    parameter int CODE_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    output logic              o_load_ready,
    input  logic [MASK_W-1:0] i_mask,
    input  logic [CODE_W-1:0] i_fin_code,
    input  logic              i_confirm,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_cmd_valid,
    output logic [CODE_W-1:0] o_cmd_code,
    output logic              o_confirm_reset,
    output logic              o_last
);
    import kdlp_pkg::*;

    logic              r_busy;
    logic [MASK_W-1:0] r_mask;
    logic [CODE_W-1:0] r_fin_code;
    logic              r_confirm;
    logic [MASK_W-1:0] w_low;
    logic              w_fire;
    logic              w_load;

    // lowest pending command goes first; top bit is end or reset
    assign w_low = r_mask & (~r_mask + {{(MASK_W-1){1'b0}}, 1'b1});

    always_comb begin
        o_cmd_code = '0;
        for (int i = 0; i < MASK_W - 1; i++) begin
            if (w_low[i]) begin
                o_cmd_code = o_cmd_code | CODE_W'(i);
            end
        end
        if (w_low[MASK_W-1]) begin
            o_cmd_code = r_fin_code;
        end
    end

    assign o_valid         = r_busy;
    assign o_cmd_valid     = |r_mask;
    assign o_confirm_reset = r_confirm;
    assign o_last          = (r_mask & ~w_low) == '0;
    assign w_fire          = r_busy && !i_stall;
    assign o_load_ready    = !r_busy || (w_fire && o_last);
    assign w_load          = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_busy <= 1'b1;
        end else if (w_fire && o_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mask     <= i_mask;
            r_fin_code <= i_fin_code;
            r_confirm  <= i_confirm;
        end else if (w_fire) begin
            r_mask     <= r_mask & ~w_low;
        end
    end

`ifndef SYNTHESIS
    a_idle_beat_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_cmd_valid) |-> o_last)
        else $error("empty beat not marked last");
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last && !i_load_valid) |=> !o_valid)
        else $error("output still valid after last beat");
`endif

endmodule

// ===== src/keypad_debounce_long_press.sv =====
`timescale 1ns / 1ps
// a taken tick is registered in stage A and then loaded into the output register,
//   which offers its first result beat; a busy or stalled output register holds stage A
// throughput: one result beat per cycle while i_stall is low; a tick gives max(1, commands)
//   beats, at most NUM_BUTTONS, which the single output register sends one by one
// a new tick is taken every cycle while the output side keeps up and each tick gives one beat
// reset: synchronous active low; registers back to 200/2000/600, timestamps and
//   hold state cleared, pipeline empty

module keypad_debounce_long_press #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tick channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [NUM_BUTTONS-1:0]                 i_button_levels,
    input  logic [kdlp_pkg::TIME_W-1:0]            i_now_ms,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_cmd_valid,
    output logic [$clog2(NUM_BUTTONS+1)-1:0]       o_cmd_code,
    output logic                                   o_confirm_reset,
    output logic                                   o_last,
    // register write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [kdlp_pkg::CIDX_W-1:0]            i_cfg_index,
    input  logic [kdlp_pkg::CFG_W-1:0]             i_cfg_data
);
    import kdlp_pkg::*;

    localparam int CODE_W = $clog2(NUM_BUTTONS + 1);
    localparam int MASK_W = NUM_BUTTONS + 1;
    localparam int EXT_W  = MAX_BUTTONS + 1;

    // configuration registers
    logic [CFG_W-1:0] r_debounce_ms;
    logic [CFG_W-1:0] r_long_press_ms;
    logic [CFG_W-1:0] r_confirm_ms;

    // stage between lanes and output register
    logic              r_a_valid;
    logic [MASK_W-1:0] r_a_mask;
    logic [CODE_W-1:0] r_a_code;
    logic              r_a_conf;
    logic [MASK_W-1:0] n_a_mask;
    logic [CODE_W-1:0] n_a_code;

    logic                 w_accept;
    logic                 w_a_move;
    logic                 w_merge_ready;
    logic [EXT_W-1:0]     w_levels_ext;
    logic [NUM_BUTTONS-1:0] w_hit;
    t_end_res             w_end;

    // registers can always be written
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RST;
            r_long_press_ms <= LONG_PRESS_RST;
            r_confirm_ms    <= CONFIRM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS: r_long_press_ms <= i_cfg_data;
                CFG_CONFIRM:    r_confirm_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tick handshake: stage A frees up when it hands off to the output register
    assign w_a_move = r_a_valid && w_merge_ready;
    assign o_stall  = r_a_valid && !w_merge_ready;
    assign w_accept = i_valid && !o_stall;

    // pad levels as released so the end button bit exists for any width
    assign w_levels_ext = {{(EXT_W-NUM_BUTTONS){1'b1}}, i_button_levels};

    // one debounce lane per plain button
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        if (g == END_BUTTON) begin : g_end_slot
            assign w_hit[g] = 1'b0;
        end else begin : g_plain
            kdlp_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_accept      (w_accept),
                .i_down        (!i_button_levels[g]),
                .i_now_ms      (i_now_ms),
                .i_debounce_ms (r_debounce_ms),
                .o_hit         (w_hit[g])
            );
        end
    end

    // end button timing lane
    kdlp_end_lane u_end_lane (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_down          (!w_levels_ext[END_BUTTON]),
        .i_now_ms        (i_now_ms),
        .i_long_press_ms (r_long_press_ms),
        .i_confirm_ms    (r_confirm_ms),
        .o_res           (w_end)
    );

    // plain hits in button order, end or reset rides in the top slot
    assign n_a_mask = {w_end.fire, w_hit};
    assign n_a_code = w_end.is_reset ? CODE_W'(NUM_BUTTONS) : CODE_W'(END_BUTTON);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept) begin
            r_a_valid <= 1'b1;
        end else if (w_a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_mask <= n_a_mask;
            r_a_code <= n_a_code;
            r_a_conf <= w_end.confirm;
        end
    end

    // output register sends pending commands one beat at a time
    kdlp_merge #(
        .MASK_W (MASK_W),
        .CODE_W (CODE_W)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load_valid    (r_a_valid),
        .o_load_ready    (w_merge_ready),
        .i_mask          (r_a_mask),
        .i_fin_code      (r_a_code),
        .i_confirm       (r_a_conf),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cmd_valid     (o_cmd_valid),
        .o_cmd_code      (o_cmd_code),
        .o_confirm_reset (o_confirm_reset),
        .o_last          (o_last)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && o_valid))
        else $error("tick stalled with free pipeline");
`endif

endmodule

// ===== test/keypad_debounce_long_press_test.sv =====
`timescale 1ns / 1ps

module keypad_debounce_long_press_test;
    import kdlp_pkg::*;

    localparam int NUM_BUTTONS = 6;
    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT = 36;

    // the index past the last register, writes to it must be dropped
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    // button level patterns, a 0 bit means pressed
    localparam logic [31:0] LV_NONE = 32'h3F;
    localparam logic [31:0] LV_ALL  = 32'h00;
    localparam logic [31:0] LV_OUT  = 32'h3E;
    localparam logic [31:0] LV_END  = 32'h37;
    localparam logic [31:0] LV_DEC  = 32'h1F;

    typedef enum logic [2:0] {
        CMD_OUT   = 3'd0,
        CMD_BACK  = 3'd1,
        CMD_START = 3'd2,
        CMD_END   = 3'd3,
        CMD_INC   = 3'd4,
        CMD_DEC   = 3'd5,
        CMD_RESET = 3'd6
    } cmd_e;

    // one result beat as the block should send it
    typedef struct packed {
        logic cmd_valid;
        cmd_e code;
        logic confirm;
        logic last;
    } beat_t;

    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } row_kind_e;

    // directed stimulus: a tick (levels, timestamp) or a register write (index, data)
    typedef struct packed {
        row_kind_e   kind;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic        typed;
        logic        exp_cmd;
        cmd_e        exp_code;
        logic        exp_confirm;
    } plan_row_t;

    localparam int PLAN_LEN = 27;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // right after reset: nothing pressed, then early presses are locked out
        '{ROW_TICK, LV_NONE, 32'd0,    1'b1, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_ALL,  32'd100,  1'b1, 1'b0, CMD_OUT, 1'b0},
        // short end press released -> end command
        '{ROW_TICK, LV_NONE, 32'd300,  1'b1, 1'b1, CMD_END, 1'b0},
        // plain lockout: accepted, equal to debounce rejected, one past accepted
        '{ROW_TICK, LV_OUT,  32'd300,  1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_OUT,  32'd500,  1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_OUT,  32'd501,  1'b0, 1'b0, CMD_OUT, 1'b0},
        // long hold: start, confirm shows, reset fires at exactly long press
        '{ROW_TICK, LV_END,  32'd1000, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_END,  32'd1601, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_END,  32'd3000, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_END,  32'd3500, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_NONE, 32'd3600, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_ALL,  32'd5000, 1'b0, 1'b0, CMD_OUT, 1'b0},
        // all registers at zero, unused index must not disturb them
        '{ROW_CFG,  32'(CFG_DEBOUNCE),   32'h0,    1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_CFG,  32'(CFG_LONG_PRESS), 32'h0,    1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_CFG,  32'(CFG_CONFIRM),    32'h0,    1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_CFG,  32'(CFG_UNUSED),     32'hFFFF, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_NONE, 32'd5001, 1'b0, 1'b0, CMD_OUT, 1'b0},
        // every button at once with zero long press: six beats in one tick
        '{ROW_TICK, LV_ALL,  32'd5002, 1'b0, 1'b0, CMD_OUT, 1'b0},
        // all registers at their top value
        '{ROW_CFG,  32'(CFG_DEBOUNCE),   32'hFFFF, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_CFG,  32'(CFG_LONG_PRESS), 32'hFFFF, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_CFG,  32'(CFG_CONFIRM),    32'hFFFF, 1'b0, 1'b0, CMD_OUT, 1'b0},
        // held after reset already sent: silent
        '{ROW_TICK, LV_ALL,  32'd5003, 1'b1, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_NONE, 32'd5004, 1'b0, 1'b0, CMD_OUT, 1'b0},
        // hold across the timestamp wrap
        '{ROW_TICK, LV_END,  32'hFFFF_FFF0, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_END,  32'h0000_0100, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_DEC,  32'h0002_0000, 1'b0, 1'b0, CMD_OUT, 1'b0},
        '{ROW_TICK, LV_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, CMD_OUT, 1'b0}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [NUM_BUTTONS-1:0]             i_button_levels = '1;
    logic [TIME_W-1:0]                  i_now_ms = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic                               o_cmd_valid;
    logic [$clog2(NUM_BUTTONS+1)-1:0]   o_cmd_code;
    logic                               o_confirm_reset;
    logic                               o_last;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [CIDX_W-1:0]                  i_cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]                   i_cfg_data = '0;

    keypad_debounce_long_press #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_button_levels(i_button_levels),
        .i_now_ms(i_now_ms),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_cmd_valid(o_cmd_valid),
        .o_cmd_code(o_cmd_code),
        .o_confirm_reset(o_confirm_reset),
        .o_last(o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------
    // keypad predictor: its own copy of registers and button timing state
    // -------------------------------------------------------------------
    logic [CFG_W-1:0]  debounce_lim = DEBOUNCE_RST;
    logic [CFG_W-1:0]  long_lim = LONG_PRESS_RST;
    logic [CFG_W-1:0]  confirm_lim = CONFIRM_RST;
    logic [TIME_W-1:0] accept_at [NUM_BUTTONS] = '{default: '0};
    logic [TIME_W-1:0] hold_from = '0;
    logic              end_was_down = 1'b0;
    logic              reset_fired = 1'b0;

    beat_t tick_beats [$];    // beats of the tick just worked out
    beat_t pending_beats [$]; // beats still owed by the block, oldest first
    int    fail_count = 0;

    // work out the beats that one tick causes and advance the predictor
    function automatic void predict_tick(input logic [NUM_BUTTONS-1:0] lv,
                                         input logic [TIME_W-1:0] nw);
        logic confirm;
        tick_beats.delete();
        // plain buttons in button order, lockout measured with wrapping time
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (b != END_BUTTON && !lv[b] && (nw - accept_at[b]) > 32'(debounce_lim)) begin
                accept_at[b] = nw;
                tick_beats.push_back('{1'b1, cmd_e'(b), 1'b0, 1'b0});
            end
        end
        // end button: long hold fires reset once, early release gives end
        if (!lv[END_BUTTON]) begin
            if (!end_was_down) begin
                hold_from = nw;
                end_was_down = 1'b1;
            end
            if (!reset_fired && (nw - hold_from) >= 32'(long_lim)) begin
                tick_beats.push_back('{1'b1, CMD_RESET, 1'b0, 1'b0});
                reset_fired = 1'b1;
            end
        end else begin
            if (end_was_down && !reset_fired)
                tick_beats.push_back('{1'b1, CMD_END, 1'b0, 1'b0});
            end_was_down = 1'b0;
            reset_fired = 1'b0;
        end
        // a quiet tick still sends one beat
        if (tick_beats.size() == 0)
            tick_beats.push_back('{1'b0, CMD_OUT, 1'b0, 1'b0});
        // confirm is strictly past the limit and the same on every beat
        confirm = end_was_down && !reset_fired && (nw - hold_from) > 32'(confirm_lim);
        foreach (tick_beats[k])
            tick_beats[k].confirm = confirm;
        tick_beats[tick_beats.size()-1].last = 1'b1;
    endfunction

    // -------------------------------------------------------------------
    // tick sender and register writer, each called at a falling edge
    // -------------------------------------------------------------------
    logic no_gaps = 1'b0;    // long stretch with neither side idling
    logic hold_go = 1'b0;    // asks the receiver for one long hold-off

    task automatic send_tick(input logic [NUM_BUTTONS-1:0] lv, input logic [TIME_W-1:0] nw,
                             input logic typed, input beat_t typed_beat);
        // random idle cycles before the beat
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_button_levels = lv;
        i_now_ms = nw;
        do @(posedge i_clk); while (o_stall);
        predict_tick(lv, nw);
        // directed rows with an obvious answer use the typed beat instead
        if (typed)
            pending_beats.push_back(typed_beat);
        else
            foreach (tick_beats[k])
                pending_beats.push_back(tick_beats[k]);
        @(negedge i_clk);
    endtask

    // drop valid and wait until every owed beat has come back
    task automatic drain_ticks();
        i_valid = 1'b0;
        while (pending_beats.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE:   debounce_lim = data;
            CFG_LONG_PRESS: long_lim = data;
            CFG_CONFIRM:    confirm_lim = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly small values so that presses get through, sometimes the extremes
    function automatic logic [CFG_W-1:0] pick_limit(input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return CFG_W'($urandom_range(0, hi));
    endfunction

    // -------------------------------------------------------------------
    // result side: stall driver and beat checker
    // -------------------------------------------------------------------
    int  stall_left = 0;
    logic hold_taken = 1'b0;

    always @(negedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        beat_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = pending_beats.pop_front();
                check_field("cmd_valid", 32'(want.cmd_valid), 32'(o_cmd_valid));
                check_field("cmd_code", 32'(want.code), 32'(o_cmd_code));
                check_field("confirm_reset", 32'(want.confirm), 32'(o_confirm_reset));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // watchdog
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("keypad_debounce_long_press_test: FAIL");
        $finish;
    end

    // -------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------
    initial begin
        logic [TIME_W-1:0]      clock_ms;
        logic [NUM_BUTTONS-1:0] lv;
        int                     end_hold_ticks;
        int unsigned            r;

        clock_ms = '0;
        end_hold_ticks = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        foreach (PLAN[row]) begin
            if (PLAN[row].kind == ROW_CFG) begin
                drain_ticks();
                write_reg(PLAN[row].arg_a[CIDX_W-1:0], PLAN[row].arg_b[CFG_W-1:0]);
            end else begin
                send_tick(PLAN[row].arg_a[NUM_BUTTONS-1:0], PLAN[row].arg_b, PLAN[row].typed,
                          '{PLAN[row].exp_cmd, PLAN[row].exp_code, PLAN[row].exp_confirm, 1'b1});
            end
        end

        // random phases, each with fresh register settings
        for (int phase = 0; phase < 6; phase++) begin
            drain_ticks();
            no_gaps = (phase == 1);
            write_reg(CFG_DEBOUNCE, pick_limit(300));
            write_reg(CFG_LONG_PRESS, pick_limit(1500));
            write_reg(CFG_CONFIRM, pick_limit(1000));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_UNUSED, CFG_W'($urandom));
            // receiver holds off for a long stretch while ticks keep coming
            if (phase == 2)
                hold_go = 1'b1;
            // walk the timestamp over the wrap point
            if (phase == 4)
                clock_ms = 32'hFFFF_F000;

            for (int n = 0; n < 23; n++) begin
                // sender waits for the block to empty out once
                if (phase == 3 && n == 13)
                    drain_ticks();

                // time mostly moves in small steps, now and then far or anywhere
                r = $urandom_range(0, 99);
                if (r < 3)
                    clock_ms = $urandom;
                else if (r < 10)
                    clock_ms = clock_ms + $urandom_range(0, 3000);
                else
                    clock_ms = clock_ms + $urandom_range(0, 60);

                // plain buttons pressed about a quarter of the time
                lv = ~NUM_BUTTONS'($urandom_range(0, 63) & $urandom_range(0, 63));

                // end button follows hold-then-release sequences, with some chatter
                if (end_hold_ticks > 0) begin
                    lv[END_BUTTON] = 1'b0;
                    end_hold_ticks--;
                end else if ($urandom_range(0, 99) < 20) begin
                    lv[END_BUTTON] = 1'b0;
                    end_hold_ticks = $urandom_range(1, 60);
                end else begin
                    lv[END_BUTTON] = 1'b1;
                end
                if ($urandom_range(0, 99) < 8)
                    lv[END_BUTTON] = 1'($urandom_range(0, 1));

                send_tick(lv, clock_ms, 1'b0, '0);
            end
        end

        // let everything owed come out, then keep watching for strays
        drain_ticks();
        no_gaps = 1'b0;
        repeat (10) @(negedge i_clk);

        if (fail_count == 0)
            $display("keypad_debounce_long_press_test: PASS");
        else
            $display("keypad_debounce_long_press_test: FAIL");
        $finish;
    end

endmodule
